// ----- sv/tin_bhq_pkg.sv -----
// Shared constants, widths and codes for the TIN height query block.
package tin_bhq_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int MAX_FACES_DEF  = 8192;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 13;
  localparam int COORD_W = 32;
  localparam int VERT_W  = 12;
  localparam int FCNT_W  = 14;

  localparam int PT_W    = 3 * COORD_W;
  localparam int FACE_W  = 3 * VERT_W;

  // datapath widths
  localparam int DIF_W   = COORD_W + 1;       // coordinate difference
  localparam int PROD_W  = 2 * DIF_W;         // one shared multiplier
  localparam int ACC_W   = PROD_W + 1;        // cross product
  localparam int REM_W   = ACC_W + 1;         // divider remainder
  localparam int Q_W     = 18;                // weight magnitude, Q16 up to 2.0
  localparam int WT_W    = 21;                // u = 1 - v - w
  localparam int HACC_W  = 56;                // height accumulator
  localparam int FRAC_W  = 16;

  localparam int ONE_Q16     = 65536;
  localparam int MIN_WEIGHT  = -65;
  localparam int DEGEN_LIMIT = 33;
  localparam logic [COORD_W-1:0] OUTSIDE_HEIGHT = 32'hFFF0_6400;  // -999 m

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT = 2'd0,
    KIND_FACE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

endpackage

// ----- sv/tin_bhq_if.sv -----
// Channel interfaces: input words, result words and the configuration write.
interface tin_bhq_in_if import tin_bhq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [VERT_W-1:0]         vert_a;
  logic [VERT_W-1:0]         vert_b;
  logic [VERT_W-1:0]         vert_c;
  modport source (output valid, kind, slot, coord_x, coord_y, coord_z,
                  vert_a, vert_b, vert_c, input ready);
  modport sink   (input valid, kind, slot, coord_x, coord_y, coord_z,
                  vert_a, vert_b, vert_c, output ready);
endinterface

interface tin_bhq_out_if import tin_bhq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] height;
  logic                      found;
  modport source (output valid, height, found, input ready);
  modport sink   (input valid, height, found, output ready);
endinterface

interface tin_bhq_cfg_if import tin_bhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FCNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/tin_barycentric_height_query_top.sv -----
// Top level: point and face tables, face scan sequencer and shared multiplier.
//   channel | dir | payload                                        | accepted when
//   in_s    | in  | kind slot coord_x coord_y coord_z vert_a/b/c   | valid & ready
//   out_s   | out | height found                                   | valid & ready
//   cfg_s   | in  | data (face_count)                              | valid & ready
// A query scans the faces one by one; per face it does one face read, three point reads,
// 7 multiplier steps, two divisions and 4 more multiplier steps, fewer when the weights
// fail or the face is degenerate or far. Faces go one at a time through the single read
// port of each table and the one multiplier.
// Reset (rst_n low, synchronous) clears control state and face_count; tables are not cleared.
// A finished result waits in the output register while further words are taken; a later
// query holds in its last state until that register is free.
module tin_barycentric_height_query_top import tin_bhq_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_FACES  = MAX_FACES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tin_bhq_in_if.sink    in_s,
  tin_bhq_out_if.source out_s,
  tin_bhq_cfg_if.sink   cfg_s
);

  localparam int PA_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int FA_W  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FC_W  = $clog2(MAX_FACES + 1);
  localparam int CNT_W = (FC_W > FCNT_W) ? FC_W : FCNT_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FACE = 15'h0002,
    S_PT0  = 15'h0004,
    S_PT1  = 15'h0008,
    S_PT2  = 15'h0010,
    S_DIFF = 15'h0020,
    S_MUL  = 15'h0040,
    S_CHK  = 15'h0080,
    S_DIVV = 15'h0100,
    S_DIVW = 15'h0200,
    S_WT   = 15'h0400,
    S_HMUL = 15'h0800,
    S_FIN  = 15'h1000,
    S_NEXT = 15'h2000,
    S_DONE = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [FCNT_W-1:0] face_count_r;
  logic [CNT_W-1:0]  cnt_r, limit;
  logic              in_acc;

  // tables
  logic               pt_we, fc_we, pt_re, fc_re;
  logic [PA_W-1:0]    pt_waddr, pt_raddr;
  logic [FA_W-1:0]    fc_waddr, fc_raddr;
  logic [PT_W-1:0]    pt_rdata;
  logic [FACE_W-1:0]  fc_rdata;
  logic [PA_W+SLOT_W-1:0] pt_slot_x;
  logic [FA_W+SLOT_W-1:0] fc_slot_x;
  logic [PA_W+VERT_W-1:0] vsel_x;
  logic [VERT_W-1:0]  vsel, va, vb, vc, vb_r, vc_r;
  logic               vert_ok;

  // datapath
  logic signed [COORD_W-1:0] qx_r, qy_r, x0_r, y0_r, z0_r, x1_r, y1_r, z1_r, z2_r;
  logic signed [COORD_W-1:0] x2, y2;
  logic signed [DIF_W-1:0]   ax_r, ay_r, bx_r, by_r, px_r, py_r, mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p, prod_r;
  logic signed [ACC_W-1:0]   prod_x, d_r, nv_r, nw_r;
  logic [REM_W-1:0]          d_x, d_abs;
  logic [2:0]                mstep_r;
  logic signed [Q_W:0]       v_r, w_r, quo;
  logic signed [WT_W-1:0]    u_c, u_r;
  logic signed [HACC_W-1:0]  hacc_r, hs;
  logic                      div_start, div_done, div_far;
  logic signed [ACC_W-1:0]   div_num;

  logic [COORD_W-1:0] res_height_r, out_height_r;
  logic               res_found_r, out_found_r, out_valid_r;

  assign in_s.ready  = (state_r == S_IDLE);
  assign in_acc      = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;

  assign limit = (CNT_W'(face_count_r) > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES)
                                                             : CNT_W'(face_count_r);

  // ---- table ports
  assign pt_slot_x = {{PA_W{1'b0}}, in_s.slot};
  assign fc_slot_x = {{FA_W{1'b0}}, in_s.slot};
  assign pt_waddr  = pt_slot_x[PA_W-1:0];
  assign fc_waddr  = fc_slot_x[FA_W-1:0];
  assign pt_we = in_acc && (in_s.kind == KIND_POINT) && (32'(in_s.slot) < 32'(MAX_POINTS));
  assign fc_we = in_acc && (in_s.kind == KIND_FACE) && (32'(in_s.slot) < 32'(MAX_FACES));

  assign va = fc_rdata[VERT_W-1:0];
  assign vb = fc_rdata[2*VERT_W-1:VERT_W];
  assign vc = fc_rdata[3*VERT_W-1:2*VERT_W];
  assign vert_ok = (32'(va) < 32'(MAX_POINTS)) && (32'(vb) < 32'(MAX_POINTS)) &&
                   (32'(vc) < 32'(MAX_POINTS));

  always_comb begin
    unique case (state_r)
      S_PT1:   vsel = vb_r;
      S_PT2:   vsel = vc_r;
      default: vsel = va;
    endcase
  end
  assign vsel_x   = {{PA_W{1'b0}}, vsel};
  assign pt_raddr = vsel_x[PA_W-1:0];
  assign pt_re    = (state_r == S_PT0) || (state_r == S_PT1) || (state_r == S_PT2);
  assign fc_raddr = cnt_r[FA_W-1:0];
  assign fc_re    = (state_r == S_FACE);

  tin_bhq_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk, .we(pt_we), .waddr(pt_waddr),
    .wdata({in_s.coord_z, in_s.coord_y, in_s.coord_x}),
    .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
  );

  tin_bhq_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_fc_ram (
    .clk, .we(fc_we), .waddr(fc_waddr),
    .wdata({in_s.vert_c, in_s.vert_b, in_s.vert_a}),
    .re(fc_re), .raddr(fc_raddr), .rdata(fc_rdata)
  );

  assign x2 = $signed(pt_rdata[COORD_W-1:0]);
  assign y2 = $signed(pt_rdata[2*COORD_W-1:COORD_W]);

  // ---- shared multiplier: cross products, then the height blend
  always_comb begin
    mul_a = ax_r;
    mul_b = by_r;
    if (state_r == S_HMUL) begin
      unique case (mstep_r)
        3'd0:    begin mul_a = DIF_W'(u_r); mul_b = DIF_W'(z0_r); end
        3'd1:    begin mul_a = DIF_W'(v_r); mul_b = DIF_W'(z1_r); end
        default: begin mul_a = DIF_W'(w_r); mul_b = DIF_W'(z2_r); end
      endcase
    end else begin
      unique case (mstep_r)
        3'd0:    begin mul_a = ax_r; mul_b = by_r; end
        3'd1:    begin mul_a = ay_r; mul_b = bx_r; end
        3'd2:    begin mul_a = px_r; mul_b = by_r; end
        3'd3:    begin mul_a = py_r; mul_b = bx_r; end
        3'd4:    begin mul_a = ax_r; mul_b = py_r; end
        default: begin mul_a = ay_r; mul_b = px_r; end
      endcase
    end
  end
  assign mul_p  = mul_a * mul_b;
  assign prod_x = {prod_r[PROD_W-1], prod_r};

  assign d_x   = {d_r[ACC_W-1], d_r};
  assign d_abs = d_r[ACC_W-1] ? (~d_x + 1'b1) : d_x;

  assign u_c = WT_W'(ONE_Q16) - WT_W'(v_r) - WT_W'(w_r);
  assign hs  = hacc_r >>> FRAC_W;

  // ---- divider
  assign div_start = ((state_r == S_CHK) && (d_abs > REM_W'(DEGEN_LIMIT))) ||
                     ((state_r == S_DIVV) && div_done && !div_far);
  assign div_num   = (state_r == S_DIVV) ? nw_r : nv_r;

  tin_bhq_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(d_r),
    .done(div_done), .far(div_far), .quo
  );

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_s.kind == KIND_QUERY) begin
        state_nxt = (limit == '0) ? S_DONE : S_FACE;
      end
      S_FACE: state_nxt = S_PT0;
      S_PT0:  state_nxt = vert_ok ? S_PT1 : S_NEXT;
      S_PT1:  state_nxt = S_PT2;
      S_PT2:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  if (mstep_r == 3'd6) state_nxt = S_CHK;
      S_CHK:  state_nxt = div_start ? S_DIVV : S_NEXT;
      S_DIVV: if (div_done) state_nxt = div_far ? S_NEXT : S_DIVW;
      S_DIVW: if (div_done) state_nxt = div_far ? S_NEXT : S_WT;
      S_WT: begin
        if (u_c < MIN_WEIGHT || v_r < MIN_WEIGHT || w_r < MIN_WEIGHT) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_HMUL;
        end
      end
      S_HMUL: if (mstep_r == 3'd3) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_NEXT: state_nxt = (CNT_W'(cnt_r + 1'b1) >= limit) ? S_DONE : S_FACE;
      S_DONE: if (!out_valid_r || out_s.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      face_count_r <= '0;
      out_valid_r  <= 1'b0;
      mstep_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_s.valid) begin
        face_count_r <= cfg_s.data;
      end
      if (out_valid_r && out_s.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DONE && (!out_valid_r || out_s.ready)) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_MUL || state_r == S_HMUL) begin
        mstep_r <= (state_nxt == state_r) ? mstep_r + 1'b1 : 3'd0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        qx_r         <= in_s.coord_x;
        qy_r         <= in_s.coord_y;
        cnt_r        <= '0;
        res_height_r <= OUTSIDE_HEIGHT;
        res_found_r  <= 1'b0;
      end
      S_PT0: begin
        vb_r <= vb;
        vc_r <= vc;
      end
      S_PT1: begin
        x0_r <= $signed(pt_rdata[COORD_W-1:0]);
        y0_r <= $signed(pt_rdata[2*COORD_W-1:COORD_W]);
        z0_r <= $signed(pt_rdata[3*COORD_W-1:2*COORD_W]);
      end
      S_PT2: begin
        x1_r <= $signed(pt_rdata[COORD_W-1:0]);
        y1_r <= $signed(pt_rdata[2*COORD_W-1:COORD_W]);
        z1_r <= $signed(pt_rdata[3*COORD_W-1:2*COORD_W]);
      end
      S_DIFF: begin
        z2_r <= $signed(pt_rdata[3*COORD_W-1:2*COORD_W]);
        ax_r <= DIF_W'(x1_r) - DIF_W'(x0_r);
        ay_r <= DIF_W'(y1_r) - DIF_W'(y0_r);
        bx_r <= DIF_W'(x2) - DIF_W'(x0_r);
        by_r <= DIF_W'(y2) - DIF_W'(y0_r);
        px_r <= DIF_W'(qx_r) - DIF_W'(x0_r);
        py_r <= DIF_W'(qy_r) - DIF_W'(y0_r);
      end
      S_MUL: begin
        prod_r <= mul_p;
        // fold in the product issued one step earlier
        unique case (mstep_r)
          3'd0:    ;
          3'd1:    d_r  <= prod_x;
          3'd2:    d_r  <= d_r - prod_x;
          3'd3:    nv_r <= prod_x;
          3'd4:    nv_r <= nv_r - prod_x;
          3'd5:    nw_r <= prod_x;
          default: nw_r <= nw_r - prod_x;
        endcase
      end
      S_DIVV: if (div_done) v_r <= quo;
      S_DIVW: if (div_done) w_r <= quo;
      S_WT:   u_r <= u_c;
      S_HMUL: begin
        prod_r <= mul_p;
        unique case (mstep_r)
          3'd0:    ;
          3'd1:    hacc_r <= prod_r[HACC_W-1:0];
          default: hacc_r <= hacc_r + prod_r[HACC_W-1:0];
        endcase
      end
      S_FIN: begin
        res_found_r <= 1'b1;
        if (&hs[HACC_W-1:COORD_W-1] || ~|hs[HACC_W-1:COORD_W-1]) begin
          res_height_r <= hs[COORD_W-1:0];
        end else begin
          res_height_r <= hs[HACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                       : {1'b0, {(COORD_W-1){1'b1}}};
        end
      end
      S_NEXT: cnt_r <= CNT_W'(cnt_r + 1'b1);
      S_DONE: if (!out_valid_r || out_s.ready) begin
        out_height_r <= res_height_r;
        out_found_r  <= res_found_r;
      end
      default: ;
    endcase
  end

  assign out_s.valid  = out_valid_r;
  assign out_s.height = $signed(out_height_r);
  assign out_s.found  = out_found_r;

endmodule

// ----- sv/tin_bhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tin_bhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/tin_bhq_div.sv -----
// Bit-serial signed divider giving a Q16 weight n/d, truncated, with a range check.
module tin_bhq_div import tin_bhq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    done,
  output logic                    far,
  output logic signed [Q_W:0]     quo
);

  localparam logic [4:0] STEP_LAST = 5'(Q_W);

  logic [REM_W-1:0] rem_r, den_r, num_x, den_x, num_abs, den_abs, rem_sh;
  logic [Q_W-1:0]   q_r;
  logic [4:0]       step_r;
  logic             run_r, done_r, far_r, neg_r;

  assign num_x   = {num[ACC_W-1], num};
  assign den_x   = {den[ACC_W-1], den};
  assign num_abs = num[ACC_W-1] ? (~num_x + 1'b1) : num_x;
  assign den_abs = den[ACC_W-1] ? (~den_x + 1'b1) : den_x;
  assign rem_sh  = {rem_r[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      far_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        rem_r  <= num_abs;
        den_r  <= den_abs;
        neg_r  <= num[ACC_W-1] ^ den[ACC_W-1];
        q_r    <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == '0) begin
          // weight beyond 2.0 in magnitude: reject without dividing
          if ({den_r[REM_W-2:0], 1'b0} < rem_r) begin
            done_r <= 1'b1;
            far_r  <= 1'b1;
            run_r  <= 1'b0;
          end
        end else if (step_r <= 5'd2) begin
          // integer part, 0..2
          if (rem_r >= den_r) begin
            rem_r <= rem_r - den_r;
            q_r   <= q_r + 1'b1;
          end
        end else begin
          if (rem_sh >= den_r) begin
            rem_r <= rem_sh - den_r;
            q_r   <= {q_r[Q_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[Q_W-2:0], 1'b0};
          end
          if (step_r == STEP_LAST) begin
            done_r <= 1'b1;
            far_r  <= 1'b0;
            run_r  <= 1'b0;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign far  = far_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ----- sv/tin_bhq_chk.sv -----
// Port-level checker for the TIN height query block, bound to the top level.
module tin_bhq_chk import tin_bhq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [KIND_W-1:0]  in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_height,
  input logic               out_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height) && $stable(out_found))
    else $error("result word changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
    else $error("input taken right after a query");

  a_miss_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_height == OUTSIDE_HEIGHT)
    else $error("miss without outside height");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind != KIND_QUERY && !out_valid |=> !out_valid)
    else $error("write word produced a result");

endmodule

bind tin_barycentric_height_query_top tin_bhq_chk u_tin_bhq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .in_kind    (in_s.kind),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_height (out_s.height),
  .out_found  (out_s.found)
);
